### rtl/acf_pkg.sv
// Shared types and constants of the audio cleanup filter chain.
package acf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 24;
  localparam int MUL_A_W  = 25;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int GAIN_W   = 17;
  localparam int LEN_W    = 32;

  localparam int Q15_SHIFT = 15;
  localparam int Q16_SHIFT = 16;

  localparam logic [MUL_B_W-1:0] DC_COEF  = MUL_B_W'(31785);
  localparam logic [MUL_B_W-1:0] LP_ALPHA = MUL_B_W'(27853);

  localparam int FADE_LENGTH_DEF = 256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MED,
    ST_DC,
    ST_LP_MUL,
    ST_LP,
    ST_GAIN,
    ST_FADE_MUL,
    ST_FADE
  } acf_state_t;

endpackage

### rtl/acf_mul.sv
// Shared signed multiplier with registered product.
module acf_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [acf_pkg::MUL_A_W-1:0]   a,
  input  logic signed [acf_pkg::MUL_B_W-1:0]   b,
  output logic signed [acf_pkg::PROD_W-1:0]    prod
);

  logic signed [acf_pkg::PROD_W-1:0] prod_r;

  // hold the product until the next issue
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

### rtl/acf_gain_div.sv
// Reciprocal multiplier for the Q16 fade gain: gain = num * 65536 / FADE_LENGTH.
module acf_gain_div #(
  parameter int FADE_LENGTH = acf_pkg::FADE_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [$clog2(FADE_LENGTH+1)-1:0]  num,
  output logic [acf_pkg::GAIN_W-1:0]        gain
);

  localparam int NW     = $clog2(FADE_LENGTH + 1);
  localparam int LOG_FL = $clog2(FADE_LENGTH);
  // num * err stays below 2^SH for every num up to FADE_LENGTH, so the floor is exact
  localparam int SH     = 2 * LOG_FL;
  localparam int MW     = LOG_FL + 18;
  localparam int PW     = NW + MW;
  localparam int GW     = acf_pkg::GAIN_W;
  localparam longint RECIP = ((longint'(1) << (acf_pkg::Q16_SHIFT + SH))
                              + longint'(FADE_LENGTH) - longint'(1)) / longint'(FADE_LENGTH);
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

  logic [NW-1:0] num_r;
  logic [GW-1:0] gain_r;
  logic [PW-1:0] prod_full;

  // hold the numerator of the current job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= '0;
    end else if (start) begin
      num_r <= num;
    end
  end

  assign prod_full = PW'(num_r) * PW'(RECIP_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else begin
      gain_r <= prod_full[SH +: GW];
    end
  end

  assign gain = gain_r;

endmodule

### rtl/audio_cleanup_filter_chain.sv
// Top level: sequencer and datapath of the audio cleanup filter chain.
// Each result runs the sequencer states MED, DC, LP_MUL, LP, GAIN, FADE_MUL and FADE and
// then loads the output register behind out_tvalid. The input is ready only in IDLE: an item
// with no result leaves the sequencer idle, one with a result runs the states once, and a final
// item with a pending sample runs them twice; a full output register holds FADE until out_tready.
// Synchronous active-low reset clears all filter history, the index and total_length.
module audio_cleanup_filter_chain #(
  parameter int FADE_LENGTH = acf_pkg::FADE_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  input  logic        in_tuser,   // [0] stream_start
  input  logic        in_tlast,   // stream_end
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_out
  output logic        out_tlast,  // final_out
  // configuration: total_length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int SW = acf_pkg::SAMPLE_W;
  localparam int AW = acf_pkg::ACC_W;
  localparam int LW = acf_pkg::LEN_W;
  localparam int MA = acf_pkg::MUL_A_W;
  localparam int MB = acf_pkg::MUL_B_W;
  localparam int PW = acf_pkg::PROD_W;
  localparam int GW = acf_pkg::GAIN_W;
  localparam int NW = $clog2(FADE_LENGTH + 1);
  localparam logic [LW-1:0] FL_LEN = LW'(FADE_LENGTH);
  localparam logic [NW-1:0] FL_N   = NW'(FADE_LENGTH);
  localparam logic signed [26:0] SAT_HI = 27'sd32767;
  localparam logic signed [26:0] SAT_LO = -27'sd32768;

  acf_pkg::acf_state_t state_r, state_nxt;

  // stream state
  logic signed [SW-1:0] pending_r;
  logic                 pending_valid_r;
  logic signed [SW-1:0] prior_r;
  logic                 prior_valid_r;
  logic signed [SW-1:0] dc_in_r;
  logic signed [AW-1:0] dc_out_r;
  logic signed [AW-1:0] lp_r;
  logic [LW-1:0]        idx_r;
  logic [LW-1:0]        total_len_r;

  // current item and job
  logic signed [SW-1:0] cur_x_r;
  logic                 cur_end_r;
  logic signed [SW-1:0] job_orig_r;
  logic                 job_final_r;
  logic signed [SW-1:0] med_r;

  // output register
  logic                 out_valid_r;
  logic [SW-1:0]        out_data_r;
  logic                 out_last_r;

  // control
  logic                 in_acc;
  logic                 pend_eff;
  logic                 mul_en;
  logic                 div_start;
  logic [GW-1:0]        gain;
  logic                 out_free;

  // arithmetic
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_q15;
  logic signed [PW-1:0] prod_q16;
  logic signed [SW-1:0] med_prev;
  logic signed [SW-1:0] med_val;
  logic signed [25:0]   dc_sum;
  logic signed [MA-1:0] lp_diff;
  logic signed [AW-1:0] lp_new;
  logic signed [26:0]   faded;
  logic signed [SW-1:0] sat_val;
  logic [NW-1:0]        n_in;
  logic [NW-1:0]        n_out;
  logic [NW-1:0]        n_gain;
  logic [LW-1:0]        left;

  function automatic logic signed [15:0] med3(input logic signed [15:0] p,
                                              input logic signed [15:0] q,
                                              input logic signed [15:0] r);
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    if (hi > r) begin
      hi = r;
    end
    return (lo > hi) ? lo : hi;
  endfunction

  assign in_acc    = in_tvalid && in_tready;
  assign pend_eff  = pending_valid_r && !in_tuser;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acf_pkg::ST_IDLE: begin
        // a sample with nothing pending and no end flag just parks
        if (in_acc && (pend_eff || in_tlast)) begin
          state_nxt = acf_pkg::ST_MED;
        end
      end
      acf_pkg::ST_MED:     state_nxt = acf_pkg::ST_DC;
      acf_pkg::ST_DC:      state_nxt = acf_pkg::ST_LP_MUL;
      acf_pkg::ST_LP_MUL:  state_nxt = acf_pkg::ST_LP;
      acf_pkg::ST_LP:      state_nxt = acf_pkg::ST_GAIN;
      acf_pkg::ST_GAIN:    state_nxt = acf_pkg::ST_FADE_MUL;
      acf_pkg::ST_FADE_MUL: state_nxt = acf_pkg::ST_FADE;
      acf_pkg::ST_FADE: begin
        if (out_free) begin
          // an end item with a pending sample runs a second job for itself
          if (!job_final_r && cur_end_r) begin
            state_nxt = acf_pkg::ST_MED;
          end else begin
            state_nxt = acf_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = acf_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs and shared multiplier operands
  // ---------------------------------------------------------------------------
  always_comb begin
    in_tready = 1'b0;
    mul_en    = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      acf_pkg::ST_IDLE: in_tready = 1'b1;
      acf_pkg::ST_MED: begin
        // DC feedback term does not depend on the median, issue it now
        mul_en    = 1'b1;
        mul_a     = MA'(dc_out_r);
        mul_b     = acf_pkg::DC_COEF;
        div_start = 1'b1;
      end
      acf_pkg::ST_LP_MUL: begin
        mul_en = 1'b1;
        mul_a  = lp_diff;
        mul_b  = acf_pkg::LP_ALPHA;
      end
      acf_pkg::ST_FADE_MUL: begin
        mul_en = 1'b1;
        mul_a  = MA'(lp_r);
        mul_b  = {1'b0, gain};
      end
      acf_pkg::ST_DC, acf_pkg::ST_LP, acf_pkg::ST_GAIN, acf_pkg::ST_FADE: begin
        mul_en = 1'b0;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath combinational terms
  // ---------------------------------------------------------------------------
  always_comb begin
    med_prev = prior_valid_r ? prior_r : job_orig_r;
    med_val  = med3(med_prev, job_orig_r, cur_x_r);

    // arithmetic shifts floor, as the recurrences require
    prod_q15 = prod >>> acf_pkg::Q15_SHIFT;
    prod_q16 = prod >>> acf_pkg::Q16_SHIFT;

    dc_sum  = 26'(med_r) - 26'(dc_in_r) + prod_q15[25:0];
    lp_diff = MA'(dc_out_r) - MA'(lp_r);
    lp_new  = lp_r + prod_q15[AW-1:0];

    // divide by 65536 toward zero: bump a negative value with a fraction
    faded = prod_q16[26:0];
    if (prod[PW-1] && (prod[acf_pkg::Q16_SHIFT-1:0] != '0)) begin
      faded = prod_q16[26:0] + 27'sd1;
    end
    if (faded > SAT_HI) begin
      sat_val = 16'sh7FFF;
    end else if (faded < SAT_LO) begin
      sat_val = -16'sh8000;
    end else begin
      sat_val = faded[SW-1:0];
    end

    // fade gain numerator: the smaller of fade-in and fade-out counts, unity at FADE_LENGTH
    n_in  = (idx_r < FL_LEN) ? (idx_r[NW-1:0] + NW'(1)) : FL_N;
    left  = (total_len_r > idx_r) ? (total_len_r - idx_r) : '0;
    n_out = (left <= FL_LEN) ? left[NW-1:0] : FL_N;
    n_gain = (n_out < n_in) ? n_out : n_in;
  end

  // ---------------------------------------------------------------------------
  // Shared units
  // ---------------------------------------------------------------------------
  acf_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  acf_gain_div #(
    .FADE_LENGTH (FADE_LENGTH)
  ) u_gain_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (n_gain),
    .gain  (gain)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      total_len_r <= cfg_data;
    end
  end

  // filter history, lookahead and index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r       <= '0;
      pending_valid_r <= 1'b0;
      prior_r         <= '0;
      prior_valid_r   <= 1'b0;
      dc_in_r         <= '0;
      dc_out_r        <= '0;
      lp_r            <= '0;
      idx_r           <= '0;
    end else begin
      if (in_acc) begin
        // start flag drops the history and any pending sample
        if (in_tuser) begin
          prior_r       <= '0;
          prior_valid_r <= 1'b0;
          dc_in_r       <= '0;
          dc_out_r      <= '0;
          lp_r          <= '0;
          idx_r         <= '0;
        end
        pending_r       <= in_tlast ? '0 : in_tdata;
        pending_valid_r <= !in_tlast;
      end
      if (state_r == acf_pkg::ST_MED) begin
        prior_r       <= job_orig_r;
        prior_valid_r <= 1'b1;
        idx_r         <= idx_r + LW'(1);
      end
      if (state_r == acf_pkg::ST_DC) begin
        dc_in_r  <= med_r;
        dc_out_r <= dc_sum[AW-1:0];
      end
      if (state_r == acf_pkg::ST_LP) begin
        lp_r <= lp_new;
      end
    end
  end

  // current item and job selection
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_x_r     <= in_tdata;
      cur_end_r   <= in_tlast;
      job_orig_r  <= pend_eff ? pending_r : in_tdata;
      job_final_r <= !pend_eff;
    end else if ((state_r == acf_pkg::ST_FADE) && out_free && !job_final_r) begin
      job_orig_r  <= cur_x_r;
      job_final_r <= 1'b1;
    end
    if (state_r == acf_pkg::ST_MED) begin
      med_r <= med_val;
    end
  end

  // output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == acf_pkg::ST_FADE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == acf_pkg::ST_FADE) && out_free) begin
      out_data_r <= sat_val;
      out_last_r <= job_final_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
